>>> src/dd_odo_pkg.sv
// Shared types, constants and the CORDIC angle table for the wheel odometry core.
// No dependencies; every other file imports this package.
package dd_odo_pkg;

  // Default sizes
  localparam int CORDIC_ITER_DEF = 16;
  localparam int COUNT_WIDTH_DEF = 32;

  // CORDIC datapath: Q2.30 values held with guard bits
  localparam int CORDIC_W = 34;
  localparam int ITER_W   = 5;
  localparam int ATAN_DEPTH = 30;
  localparam logic [CORDIC_W-1:0] CORDIC_GAIN_Q30 = CORDIC_W'(652032874);
  localparam logic signed [31:0] QUARTER_TURN = 32'sh4000_0000;
  localparam logic [31:0] HALF_TURN = 32'h8000_0000;

  // Input item
  typedef struct packed {
    logic [31:0] left_count;
    logic [31:0] right_count;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic signed [31:0] x_out;
    logic signed [31:0] y_out;
    logic [31:0]        heading_out;
  } out_item_t;

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_MUL,
    OP_HEAD,
    OP_ROT_INIT,
    OP_ROT,
    OP_SC_LO,
    OP_SC_HI,
    OP_SC_ACC,
    OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t            op;
    logic              sel_y;
    logic [ITER_W-1:0] iter;
  } dp_cmd_t;

  typedef struct packed {
    logic upd;
  } dp_stat_t;

  // atan(2^-i) in 2^-32 turns, rounded
  function automatic logic [31:0] atan_turn(input logic [ITER_W-1:0] idx);
    logic [31:0] r;
    unique case (idx)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933406;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10679838;
      5'd7:  r = 32'd5339989;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      5'd24: r = 32'd41;
      5'd25: r = 32'd20;
      5'd26: r = 32'd10;
      5'd27: r = 32'd5;
      5'd28: r = 32'd3;
      5'd29: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

>>> src/dd_odo_ctrl.sv
// Sequencer for the odometry core: steps the datapath through one item.
// Depends on dd_odo_pkg for command and status types.
module dd_odo_ctrl
  import dd_odo_pkg::*;
#(
  parameter int CORDIC_ITERATIONS = CORDIC_ITER_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output dp_cmd_t  cmd,
  input  dp_stat_t stat
);

  localparam int IW = $clog2(CORDIC_ITERATIONS);
  localparam logic [IW-1:0] ITER_LAST = IW'(CORDIC_ITERATIONS - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_HEAD,
    S_ROT_INIT,
    S_ROT,
    S_SX_LO,
    S_SX_HI,
    S_SX_ACC,
    S_SY_LO,
    S_SY_HI,
    S_SY_ACC,
    S_FIN
  } state_t;

  state_t        state;
  logic [IW-1:0] iter;
  logic          out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  // Decode the command for the current step
  always_comb begin
    cmd.op    = OP_NONE;
    cmd.sel_y = 1'b0;
    cmd.iter  = ITER_W'(iter);
    unique case (state)
      S_IDLE:     cmd.op = in_valid ? OP_CAPTURE : OP_NONE;
      S_MUL:      cmd.op = OP_MUL;
      S_HEAD:     cmd.op = OP_HEAD;
      S_ROT_INIT: cmd.op = OP_ROT_INIT;
      S_ROT:      cmd.op = OP_ROT;
      S_SX_LO:    cmd.op = OP_SC_LO;
      S_SX_HI:    cmd.op = OP_SC_HI;
      S_SX_ACC:   cmd.op = OP_SC_ACC;
      S_SY_LO: begin
        cmd.op    = OP_SC_LO;
        cmd.sel_y = 1'b1;
      end
      S_SY_HI: begin
        cmd.op    = OP_SC_HI;
        cmd.sel_y = 1'b1;
      end
      S_SY_ACC: begin
        cmd.op    = OP_SC_ACC;
        cmd.sel_y = 1'b1;
      end
      S_FIN:      cmd.op = out_free ? OP_OUT : OP_NONE;
      default:    cmd.op = OP_NONE;
    endcase
  end

  // State, rotation counter and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      iter      <= '0;
      out_valid <= 1'b0;
    end else begin
      // raise valid as a finished item loads, drop it once the waiting item is taken
      if (state == S_FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_MUL;
          end
        end
        S_MUL:      state <= stat.upd ? S_HEAD : S_FIN;
        S_HEAD:     state <= S_ROT_INIT;
        S_ROT_INIT: begin
          iter  <= '0;
          state <= S_ROT;
        end
        S_ROT: begin
          if (iter == ITER_LAST) begin
            state <= S_SX_LO;
          end else begin
            iter <= iter + 1'b1;
          end
        end
        S_SX_LO:  state <= S_SX_HI;
        S_SX_HI:  state <= S_SX_ACC;
        S_SX_ACC: state <= S_SY_LO;
        S_SY_LO:  state <= S_SY_HI;
        S_SY_HI:  state <= S_SY_ACC;
        S_SY_ACC: state <= S_FIN;
        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> src/dd_odo_dp.sv
// Datapath of the odometry core: deltas, products, CORDIC and saturating position.
// Depends on dd_odo_pkg; driven by dd_odo_ctrl through dp_cmd_t.
module dd_odo_dp
  import dd_odo_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  input  in_item_t    in_data,
  output out_item_t   out_data,
  input  logic [23:0] dist_per_count,
  input  logic [31:0] turn_per_count
);

  localparam int W  = COUNT_WIDTH;
  localparam int PW = COUNT_WIDTH + 25;  // signed travel product
  localparam int MW = COUNT_WIDTH + 24;  // its magnitude
  localparam int CW = CORDIC_W;

  // Item state
  logic [W-1:0]           prev_left_count;
  logic [W-1:0]           prev_right_count;
  logic [31:0]            heading_angle;
  logic signed [31:0]     pos_x_acc;
  logic signed [31:0]     pos_y_acc;
  logic                   upd;

  // Working registers
  logic signed [W:0]      sum_d;
  logic signed [W:0]      diff_d;
  logic signed [PW-1:0]   p_reg;
  logic [31:0]            hprod;
  logic [MW-1:0]          p_mag;
  logic                   p_neg;
  logic signed [CW-1:0]   cx;
  logic signed [CW-1:0]   cy;
  logic signed [CW-1:0]   cz;
  logic                   flip;
  logic [63:0]            pr;
  logic [31:0]            lo_carry;
  logic                   res_neg;

  // Capture: wrapped deltas
  logic [W-1:0]           left_c;
  logic [W-1:0]           right_c;
  logic signed [W-1:0]    dl;
  logic signed [W-1:0]    dr;
  logic signed [W:0]      sum_next;
  logic signed [W:0]      diff_next;

  assign left_c    = in_data.left_count[W-1:0];
  assign right_c   = in_data.right_count[W-1:0];
  assign dl        = $signed(left_c - prev_left_count);
  assign dr        = $signed(right_c - prev_right_count);
  assign sum_next  = (W+1)'(dl) + (W+1)'(dr);
  assign diff_next = (W+1)'(dr) - (W+1)'(dl);

  // Travel and heading products
  logic signed [PW:0]     p_full;
  logic signed [32:0]     diff_ext;
  logic [31:0]            hprod_next;

  assign p_full     = sum_d * $signed({1'b0, dist_per_count});
  assign diff_ext   = 33'(diff_d);
  assign hprod_next = 32'(diff_ext[31:0] * turn_per_count);

  // Fold the heading into the right half plane
  logic signed [31:0]     z0;
  logic                   fold;
  logic [31:0]            z_turned;

  assign z0       = $signed(heading_angle);
  assign fold     = (z0 > QUARTER_TURN) || (z0 < -QUARTER_TURN);
  assign z_turned = heading_angle + HALF_TURN;

  // One micro-rotation
  logic signed [CW-1:0]   xs;
  logic signed [CW-1:0]   ys;
  logic signed [CW-1:0]   atan_s;

  assign xs     = cx >>> cmd.iter;
  assign ys     = cy >>> cmd.iter;
  assign atan_s = CW'(atan_turn(cmd.iter));

  // Shared multiplier for scaling travel by cosine or sine
  logic signed [CW-1:0]   csel;
  logic signed [CW-1:0]   c_abs;
  logic                   c_neg;
  logic [31:0]            mul_a;
  logic [31:0]            mul_b;
  logic [63:0]            mul_prod;

  assign csel     = cmd.sel_y ? cy : cx;
  assign c_abs    = csel[CW-1] ? -csel : csel;
  assign c_neg    = csel[CW-1] ^ flip;
  assign mul_b    = c_abs[31:0];
  assign mul_a    = (cmd.op == OP_SC_LO) ? p_mag[31:0] : 32'(p_mag[MW-1:32]);
  assign mul_prod = 64'(mul_a) * 64'(mul_b);

  // Round, apply sign and saturate into the position
  logic [63:0]            rnd_sum;
  logic [56:0]            mag;
  logic signed [57:0]     delta;
  logic signed [31:0]     acc_sel;
  logic signed [58:0]     pos_sum;
  logic signed [31:0]     pos_sat;

  assign rnd_sum = pr + 64'(lo_carry) + 64'd64;
  assign mag     = rnd_sum[63:7];
  assign delta   = res_neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  assign acc_sel = cmd.sel_y ? pos_y_acc : pos_x_acc;
  assign pos_sum = 59'(acc_sel) + 59'(delta);

  always_comb begin
    if (pos_sum[58:31] == {28{pos_sum[58]}}) begin
      pos_sat = pos_sum[31:0];
    end else begin
      pos_sat = pos_sum[58] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
  end

  assign stat.upd = upd;

  // Item state with reset
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_left_count  <= '0;
      prev_right_count <= '0;
      heading_angle    <= '0;
      pos_x_acc        <= '0;
      pos_y_acc        <= '0;
      upd              <= 1'b0;
    end else begin
      unique case (cmd.op)
        OP_CAPTURE: begin
          upd              <= (prev_left_count != '0) && (prev_right_count != '0);
          prev_left_count  <= left_c;
          prev_right_count <= right_c;
        end
        OP_HEAD: heading_angle <= heading_angle + hprod;
        OP_SC_ACC: begin
          if (cmd.sel_y) begin
            pos_y_acc <= pos_sat;
          end else begin
            pos_x_acc <= pos_sat;
          end
        end
        default: ;
      endcase
    end
  end

  // Working registers and result
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_CAPTURE: begin
        sum_d  <= sum_next;
        diff_d <= diff_next;
      end
      OP_MUL: begin
        p_reg <= p_full[PW-1:0];
        hprod <= hprod_next;
      end
      OP_HEAD: begin
        p_neg <= p_reg[PW-1];
        p_mag <= p_reg[PW-1] ? MW'(-p_reg) : MW'(p_reg);
      end
      OP_ROT_INIT: begin
        cx   <= $signed(CORDIC_GAIN_Q30);
        cy   <= '0;
        cz   <= fold ? CW'($signed(z_turned)) : CW'(z0);
        flip <= fold;
      end
      OP_ROT: begin
        if (!cz[CW-1]) begin
          cx <= cx - ys;
          cy <= cy + xs;
          cz <= cz - atan_s;
        end else begin
          cx <= cx + ys;
          cy <= cy - xs;
          cz <= cz + atan_s;
        end
      end
      OP_SC_LO: begin
        pr      <= mul_prod;
        res_neg <= p_neg ^ c_neg;
      end
      OP_SC_HI: begin
        lo_carry <= pr[63:32];
        pr       <= mul_prod;
      end
      OP_OUT: begin
        out_data.x_out       <= pos_x_acc;
        out_data.y_out       <= pos_y_acc;
        out_data.heading_out <= heading_angle;
      end
      default: ;
    endcase
  end

endmodule

>>> src/diff_drive_wheel_odometry_core.sv
// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall    in_item_t  (left_count, right_count)
// out       output     out_valid / out_stall  out_item_t (x_out, y_out, heading_out)
// cfg       input      APB psel/penable       dist_per_count @0x0, turn_per_count @0x4
//
// An item that updates the pose is finished before the next is accepted; its work is
// set by the CORDIC loop, one micro-rotation a cycle, and the shared 32x32 multiplier
// that scales travel in two partial products per axis. An item that only stores counts
// (either previous count zero) skips the heading, CORDIC and scaling steps.
// Reset clears pose, previous counts and the registers; no clearing pass is needed.
// A stalled result holds in the output register; the core finishes the next item and
// waits for the slot to free before loading it.
module diff_drive_wheel_odometry_core
  import dd_odo_pkg::*;
#(
  parameter int CORDIC_ITERATIONS = CORDIC_ITER_DEF,
  parameter int COUNT_WIDTH       = COUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic REG_DIST = 1'b0;
  localparam logic REG_TURN = 1'b1;

  logic [23:0] dist_per_count;
  logic [31:0] turn_per_count;
  logic        cfg_wr;
  dp_cmd_t     cmd;
  dp_stat_t    stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // Register write
  always_ff @(posedge clk) begin
    if (rst) begin
      dist_per_count <= '0;
      turn_per_count <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_DIST: dist_per_count <= pwdata[23:0];
        REG_TURN: turn_per_count <= pwdata;
        default:  ;
      endcase
    end
  end

  // Register read
  always_comb begin
    unique case (paddr[2])
      REG_DIST: prdata = {8'd0, dist_per_count};
      REG_TURN: prdata = turn_per_count;
      default:  prdata = '0;
    endcase
  end

  dd_odo_ctrl #(
    .CORDIC_ITERATIONS(CORDIC_ITERATIONS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  dd_odo_dp #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .in_data        (in_data),
    .out_data       (out_data),
    .dist_per_count (dist_per_count),
    .turn_per_count (turn_per_count)
  );

endmodule

>>> src/dd_odo_chk.sv
// Port-level checks for the odometry core, bound to the top level.
// Depends on dd_odo_pkg for the payload types.
module dd_odo_chk
  import dd_odo_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Go busy after taking an item
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again right after accept");

  // A result appears only at the end of work on an item
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared while idle");

  // Come out of reset empty and ready
  a_reset_state: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("not empty after reset");

endmodule

bind diff_drive_wheel_odometry_core dd_odo_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

>>> tb/diff_drive_wheel_odometry_core_test.sv
// Self-checking testbench for diff_drive_wheel_odometry_core: drives encoder counts,
// predicts pose and heading in fixed point, and compares every result field by field.
// Depends on dd_odo_pkg (item structs) and the core RTL.
module diff_drive_wheel_odometry_core_test;
  import dd_odo_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          LIMIT_CYCLES = 200_000;
  localparam logic [2:0]  ADDR_DIST_PER_COUNT = 3'h0;
  localparam logic [2:0]  ADDR_TURN_PER_COUNT = 3'h4;
  localparam int          ROTATION_STEPS = 16;
  localparam longint      TRIG_GAIN = 64'sd652032874;
  localparam longint      QUARTER = 64'sd1073741824;
  localparam logic [31:0] HALF = 32'h8000_0000;
  localparam longint      POS_MAX = 64'sd2147483647;
  localparam longint      POS_MIN = -64'sd2147483648;
  localparam longint      ATAN_TURNS [16] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5339989, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Predicted core state and registers
  logic [23:0]        dist_cfg = '0;
  logic [31:0]        turn_cfg = '0;
  logic [31:0]        prev_lcount = '0;
  logic [31:0]        prev_rcount = '0;
  logic [31:0]        heading = '0;
  logic signed [31:0] pos_x = '0;
  logic signed [31:0] pos_y = '0;

  out_item_t   pose_expect_q [$];
  out_item_t   expected_pose;
  int          errors = 0;
  int          cycle_count = 0;
  int          sink_wait = 0;
  int          sink_hold_cycles = 0;
  bit          steady = 1'b0;
  logic [31:0] last_lcount = '0;
  logic [31:0] last_rcount = '0;

  diff_drive_wheel_odometry_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #6 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // cos and sin of a binary angle, Q2.30, by shift-add rotation
  function automatic void rotate_heading(input logic [31:0] ang, output longint cs,
                                         output longint sn);
    longint x, y, z, xs, ys;
    bit     flip;
    z = longint'($signed(ang));
    flip = (z > QUARTER) || (z < -QUARTER);
    // fold the back half-plane forward and negate at the end
    if (flip) z = longint'($signed(ang + HALF));
    x = TRIG_GAIN;
    y = 0;
    for (int i = 0; i < ROTATION_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys;
        y += xs;
        z -= ATAN_TURNS[i];
      end else begin
        x += ys;
        y -= xs;
        z += ATAN_TURNS[i];
      end
    end
    cs = flip ? -x : x;
    sn = flip ? -y : y;
  endfunction

  // travel * trig / 2^39, rounded half away from zero
  function automatic longint scale_by_trig(input longint travel, input longint trig);
    logic [127:0] mag_p, mag_t, prod;
    longint       m;
    mag_p = (travel < 0) ? 128'(-travel) : 128'(travel);
    mag_t = (trig < 0) ? 128'(-trig) : 128'(trig);
    prod = mag_p * mag_t;
    prod = (prod + (128'd1 << 38)) >> 39;
    m = longint'(prod[63:0]);
    return ((travel < 0) != (trig < 0)) ? -m : m;
  endfunction

  function automatic logic signed [31:0] sat_add32(input logic signed [31:0] acc,
                                                   input longint inc);
    longint s;
    s = longint'(acc) + inc;
    if (s > POS_MAX) return 32'sh7FFF_FFFF;
    if (s < POS_MIN) return 32'sh8000_0000;
    return s[31:0];
  endfunction

  // Advance the predicted pose by one pair of counts and return the expected result
  function automatic out_item_t advance_pose(input in_item_t it);
    logic [31:0] dl32, dr32;
    logic [63:0] turn_prod;
    longint      dl, dr, travel, cs, sn;
    out_item_t   r;
    // hold the pose while either stored count is still zero
    if (prev_lcount != 0 && prev_rcount != 0) begin
      dl32 = it.left_count - prev_lcount;
      dr32 = it.right_count - prev_rcount;
      dl = longint'($signed(dl32));
      dr = longint'($signed(dr32));
      travel = (dl + dr) * longint'(dist_cfg);
      turn_prod = (dr - dl) * longint'(turn_cfg);
      heading = heading + turn_prod[31:0];
      rotate_heading(heading, cs, sn);
      pos_x = sat_add32(pos_x, scale_by_trig(travel, cs));
      pos_y = sat_add32(pos_y, scale_by_trig(travel, sn));
    end
    prev_lcount = it.left_count;
    prev_rcount = it.right_count;
    r.x_out = pos_x;
    r.y_out = pos_y;
    r.heading_out = heading;
    return r;
  endfunction

  // Result side: check each accepted pose, then stall for a random number of cycles
  always @(posedge clk) begin
    if (out_valid && !out_stall) begin
      if (pose_expect_q.size() == 0) begin
        $display("%0t: unexpected pose x=%0d y=%0d heading=%h", $time,
                 out_data.x_out, out_data.y_out, out_data.heading_out);
        errors++;
      end else begin
        expected_pose = pose_expect_q.pop_front();
        if (out_data.x_out !== expected_pose.x_out) begin
          $display("%0t: x_out expected %0d got %0d", $time, expected_pose.x_out,
                   out_data.x_out);
          errors++;
        end
        if (out_data.y_out !== expected_pose.y_out) begin
          $display("%0t: y_out expected %0d got %0d", $time, expected_pose.y_out,
                   out_data.y_out);
          errors++;
        end
        if (out_data.heading_out !== expected_pose.heading_out) begin
          $display("%0t: heading_out expected %h got %h", $time,
                   expected_pose.heading_out, out_data.heading_out);
          errors++;
        end
      end
      sink_wait = steady ? 0 : $urandom_range(0, 4);
    end
    if (sink_hold_cycles > 0) begin
      sink_hold_cycles--;
      out_stall <= 1'b1;
    end else if (sink_wait > 0) begin
      sink_wait--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Offer one item after a random gap and return at the edge that accepts it
  task automatic send_counts(input logic [31:0] lcount, input logic [31:0] rcount);
    int       gap;
    in_item_t it;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    it.left_count = lcount;
    it.right_count = rcount;
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    pose_expect_q.push_back(advance_pose(it));
    last_lcount = lcount;
    last_rcount = rcount;
  endtask

  // Mostly small wheel steps from the last counts, some wild counts and zero counts
  task automatic send_random_counts(input int max_step);
    int          kind;
    logic [31:0] lc, rc;
    kind = $urandom_range(0, 19);
    lc = last_lcount + 32'(int'($urandom_range(0, 2 * max_step)) - max_step);
    rc = last_rcount + 32'(int'($urandom_range(0, 2 * max_step)) - max_step);
    if (kind == 0) begin
      lc = $urandom;
      rc = $urandom;
    end else if (kind == 1) begin
      if ($urandom_range(0, 1)) lc = '0;
      else rc = '0;
    end
    send_counts(lc, rc);
  endtask

  // Drop valid and hold until every expected pose has come back
  task automatic wait_for_poses();
    in_valid <= 1'b0;
    while (pose_expect_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write one register through the APB setup and access phases, then idle before returning
  task automatic write_register(input logic [2:0] addr, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (addr)
      ADDR_DIST_PER_COUNT: dist_cfg = value[23:0];
      ADDR_TURN_PER_COUNT: turn_cfg = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Pose stays put until both stored counts are nonzero
  task automatic test_skip_on_zero_counts();
    // upper byte set on purpose: it must be dropped
    write_register(ADDR_DIST_PER_COUNT, 32'hFFFF_FFFF);
    write_register(ADDR_TURN_PER_COUNT, 32'h4000_0000);
    send_counts(32'd0, 32'd0);
    send_counts(32'd100, 32'd0);
    send_counts(32'd100, 32'd100);
    send_counts(32'd100, 32'd101);
  endtask

  // Step the heading through every quadrant boundary, wrapping it, then step it backward
  task automatic test_heading_quadrants();
    send_counts(32'd100, 32'd102);
    send_counts(32'd100, 32'd103);
    send_counts(32'd100, 32'd104);
    send_counts(32'd101, 32'd104);
    wait_for_poses();
    write_register(ADDR_TURN_PER_COUNT, 32'hFFFF_FFFF);
    send_counts(32'd101, 32'd105);
  endtask

  // Wrapping deltas, the most negative delta and all-ones counts
  task automatic test_count_extremes();
    send_counts(32'hFFFF_FFF0, 32'hFFFF_FFF0);
    send_counts(32'h0000_0010, 32'h0000_0010);
    send_counts(32'h8000_0010, 32'h0000_0010);
    send_counts(32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  // Huge travel both ways drives x and y into their limits
  task automatic test_position_saturation();
    send_counts(32'd1, 32'd1);
    send_counts(32'h8000_0000, 32'h8000_0000);
    send_counts(32'd1, 32'd1);
    send_counts(32'h8000_0000, 32'h8000_0000);
    send_counts(32'd1, 32'd1);
    send_counts(32'd1, 32'd7);
    send_counts(32'h7FFF_0000, 32'h7FFF_1000);
  endtask

  // Random walks under several register settings, the last one with no idling
  task automatic test_random_odometry();
    logic [31:0] dist_val, turn_val;
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin
          dist_val = 32'h00FF_FFFF;
          turn_val = 32'hFFFF_FFFF;
        end
        1: begin
          dist_val = '0;
          turn_val = '0;
        end
        2: begin
          dist_val = 32'd10294;
          turn_val = 32'h0003_4F2C;
        end
        default: begin
          dist_val = $urandom;
          turn_val = $urandom;
        end
      endcase
      wait_for_poses();
      write_register(ADDR_DIST_PER_COUNT, dist_val);
      write_register(ADDR_TURN_PER_COUNT, turn_val);
      steady = (phase == 4);
      for (int n = 0; n < 100; n++) send_random_counts(3000);
    end
    steady = 1'b0;
  endtask

  // Hold the result side off while items keep coming, then drain before resuming
  task automatic test_output_backpressure();
    sink_hold_cycles = 300;
    for (int n = 0; n < 8; n++) send_random_counts(500);
    wait_for_poses();
    for (int n = 0; n < 6; n++) send_random_counts(500);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_skip_on_zero_counts();
    test_heading_quadrants();
    test_count_extremes();
    test_position_saturation();
    test_output_backpressure();
    test_random_odometry();
    wait_for_poses();
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
